@@ design/pcef_pkg.sv @@
// ----------------------------------------------------------------------------
// pcef_pkg
// Types and constants shared by the path/cycle edge filter modules.
// ----------------------------------------------------------------------------
package pcef_pkg;

   localparam int VERT_W  = 10;
   localparam int WT_W    = 32;
   localparam int SUM_W   = 48;
   localparam int DEPTH   = 1 << VERT_W;

   typedef enum logic [1:0] {
      KIND_INSERT,
      KIND_READ,
      KIND_BAD_INSERT,
      KIND_BAD_READ
   } kind_type;

   typedef enum logic [2:0] {
      STAT_INTERIOR = 3'd0,
      STAT_ODD      = 3'd1,
      STAT_CLOSED   = 3'd2,
      STAT_MERGED   = 3'd3,
      STAT_READ     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RB,
      ST_EV,
      ST_W2,
      ST_OUT
   } state_type;

   typedef struct packed {
      kind_type            kind;
      logic [VERT_W-1:0]   a;
      logic [VERT_W-1:0]   b;
      logic [WT_W-1:0]     wt;
   } cmd_type;

   typedef struct packed {
      logic [VERT_W-1:0]   rl;
      logic [VERT_W-1:0]   ll;
      logic [WT_W-1:0]     rw;
      logic [WT_W-1:0]     lw;
   } link_type;

   typedef struct packed {
      status_type          status;
      logic [VERT_W-1:0]   rl;
      logic [VERT_W-1:0]   ll;
      logic [WT_W-1:0]     rw;
      logic [WT_W-1:0]     lw;
      logic [VERT_W-1:0]   far;
      logic                cyc;
      logic                par;
   } res_type;

   typedef struct packed {
      logic                clearing;
      logic                pop;
   } back_stat_type;

   function automatic link_type attach(link_type l, logic [VERT_W-1:0] to,
                                       logic [WT_W-1:0] wt);
      link_type r;
      r = l;
      if (l.rl == '0) begin
         r.rl = to;
         r.rw = wt;
      end else begin
         r.ll = to;
         r.lw = wt;
      end
      return r;
   endfunction

   function automatic logic interior(link_type l);
      return (l.rl != '0) && (l.ll != '0);
   endfunction

endpackage

@@ design/path_cycle_edge_filter_unit.sv @@
// ----------------------------------------------------------------------------
// path_cycle_edge_filter_unit
// Edge filter of a path-growing 2-matching with a per-vertex link table.
// ----------------------------------------------------------------------------
// Requests enter on req_* (valid/stall): req_type 0 inserts edge
// (vertex_a, vertex_b, edge_weight), 1 reads the table entry of vertex_a.
// Every request gives exactly one response on rsp_*, in order.
// The sequencer takes one request at a time through the single read port
// of the vertex table: it reads the entry of vertex_a and, for an insert,
// then that of vertex_b, one after the other; an accepted insert then
// writes in up to two steps (ST_EV, ST_W2) before ST_OUT registers the
// response. A request with an out-of-range vertex goes straight to ST_OUT.
// After reset the table is swept one entry per cycle (all 1024 entries);
// req_stall stays high during the sweep. A stalled response holds on rsp_*;
// up to four further requests are buffered before req_stall rises.
// ----------------------------------------------------------------------------
module path_cycle_edge_filter_unit import pcef_pkg::*; #(
   parameter int MAX_VERTICES = 1023
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [VERT_W-1:0]   req_vertex_a,
   input  logic [VERT_W-1:0]   req_vertex_b,
   input  logic [WT_W-1:0]     req_edge_weight,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [VERT_W-1:0]   rsp_right_neighbor,
   output logic [VERT_W-1:0]   rsp_left_neighbor,
   output logic [WT_W-1:0]     rsp_right_link_weight,
   output logic [WT_W-1:0]     rsp_left_link_weight,
   output logic [VERT_W-1:0]   rsp_far_endpoint,
   output logic                rsp_in_cycle,
   output logic                rsp_odd_count,
   output logic [SUM_W-1:0]    rsp_total_weight
);

   logic          f_valid, f_take, q_valid;
   cmd_type       f_item, q_item;
   back_stat_type stat;

   pcef_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .req_edge_weight (req_edge_weight),
      .clearing        (stat.clearing),
      .out_valid       (f_valid),
      .out_item        (f_item),
      .out_take        (f_take)
   );

   pcef_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .in_take   (f_take),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_pop   (stat.pop)
   );

   pcef_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_valid               (q_valid),
      .q_item                (q_item),
      .stat                  (stat),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_right_neighbor    (rsp_right_neighbor),
      .rsp_left_neighbor     (rsp_left_neighbor),
      .rsp_right_link_weight (rsp_right_link_weight),
      .rsp_left_link_weight  (rsp_left_link_weight),
      .rsp_far_endpoint      (rsp_far_endpoint),
      .rsp_in_cycle          (rsp_in_cycle),
      .rsp_odd_count         (rsp_odd_count),
      .rsp_total_weight      (rsp_total_weight)
   );

endmodule

@@ design/pcef_front.sv @@
// ----------------------------------------------------------------------------
// pcef_front
// Request intake: registers one request and classifies it by vertex range.
// ----------------------------------------------------------------------------
module pcef_front import pcef_pkg::*; #(
   parameter int MAX_VERTICES = 1023
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [VERT_W-1:0]   req_vertex_a,
   input  logic [VERT_W-1:0]   req_vertex_b,
   input  logic [WT_W-1:0]     req_edge_weight,
   input  logic                clearing,
   output logic                out_valid,
   output cmd_type             out_item,
   input  logic                out_take
);

   logic    valid_ff, valid_in;
   cmd_type item_ff, item_in;
   logic    a_ok, b_ok, accept;

   assign a_ok = (req_vertex_a != '0) && (32'(req_vertex_a) <= 32'(MAX_VERTICES));
   assign b_ok = (req_vertex_b != '0) && (32'(req_vertex_b) <= 32'(MAX_VERTICES));

   assign req_stall = clearing || (valid_ff && !out_take);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in    = item_ff;
      valid_in   = valid_ff && !out_take;
      if (accept) begin
         valid_in   = 1'b1;
         item_in.a  = req_vertex_a;
         item_in.b  = req_vertex_b;
         item_in.wt = req_edge_weight;
         if (req_type)
            item_in.kind = a_ok ? KIND_READ : KIND_BAD_READ;
         else
            item_in.kind = (a_ok && b_ok) ? KIND_INSERT : KIND_BAD_INSERT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

@@ design/pcef_queue.sv @@
// ----------------------------------------------------------------------------
// pcef_queue
// Two-entry request queue between the intake and the table sequencer.
// ----------------------------------------------------------------------------
module pcef_queue import pcef_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  cmd_type in_item,
   output logic    in_take,
   output logic    out_valid,
   output cmd_type out_item,
   input  logic    out_pop
);

   cmd_type    slot_ff [0:1];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_take   = in_valid && (cnt_ff != 2'd2);
   assign push      = in_take;
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = out_pop ? ~rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(push) - 2'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push)
         slot_ff[wptr_ff] <= in_item;
   end

endmodule

@@ design/pcef_back.sv @@
// ----------------------------------------------------------------------------
// pcef_back
// Table sequencer: vertex table memories, edge evaluation and result register.
// ----------------------------------------------------------------------------
module pcef_back import pcef_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_item,
   output back_stat_type       stat,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [VERT_W-1:0]   rsp_right_neighbor,
   output logic [VERT_W-1:0]   rsp_left_neighbor,
   output logic [WT_W-1:0]     rsp_right_link_weight,
   output logic [WT_W-1:0]     rsp_left_link_weight,
   output logic [VERT_W-1:0]   rsp_far_endpoint,
   output logic                rsp_in_cycle,
   output logic                rsp_odd_count,
   output logic [SUM_W-1:0]    rsp_total_weight
);

   link_type            link_mem    [0:DEPTH-1];
   logic [VERT_W-1:0]   partner_mem [0:DEPTH-1];
   logic                cyc_mem     [0:DEPTH-1];
   logic                par_mem     [0:DEPTH-1];

   link_type            lk_rd_ff;
   logic [VERT_W-1:0]   pt_rd_ff;
   logic                cyc_rd_ff, par_rd_ff;
   logic [VERT_W-1:0]   rd_addr;

   logic                lk_we, pt_we, cyc_we, par_we;
   logic [VERT_W-1:0]   lk_waddr, nd_waddr, pt_wdata;
   link_type            lk_wdata;
   logic                cyc_wdata, par_wdata;

   state_type           state_ff, state_in;
   logic [VERT_W-1:0]   clr_ff, clr_in;
   cmd_type             cur_ff, cur_in;
   link_type            la_ff, la_in;
   logic [VERT_W-1:0]   pa_ff, pa_in;
   logic                para_ff, para_in;
   res_type             res_ff, res_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W:0]      sum_add;

   link_type            w2_link_ff, w2_link_in;
   logic [VERT_W-1:0]   w2_addr_ff, w2_addr_in, w2_pt_ff, w2_pt_in;
   logic                w2_ptwe_ff, w2_ptwe_in, w2_par_ff, w2_par_in;

   logic                out_free, pop;
   logic                rv_ff, rv_in;
   res_type             ro_ff, ro_in;
   logic [SUM_W-1:0]    rt_ff, rt_in;

   assign out_free = !rv_ff || !rsp_stall;
   assign sum_add  = {1'b0, sum_ff} + (SUM_W+1)'(cur_ff.wt);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cur_in     = cur_ff;
      la_in      = la_ff;
      pa_in      = pa_ff;
      para_in    = para_ff;
      res_in     = res_ff;
      sum_in     = sum_ff;
      w2_link_in = w2_link_ff;
      w2_addr_in = w2_addr_ff;
      w2_pt_in   = w2_pt_ff;
      w2_ptwe_in = w2_ptwe_ff;
      w2_par_in  = w2_par_ff;
      rv_in      = rv_ff && rsp_stall;
      ro_in      = ro_ff;
      rt_in      = rt_ff;
      pop        = 1'b0;
      rd_addr    = q_item.a;
      lk_we      = 1'b0;
      pt_we      = 1'b0;
      cyc_we     = 1'b0;
      par_we     = 1'b0;
      lk_waddr   = cur_ff.a;
      nd_waddr   = cur_ff.a;
      lk_wdata   = la_ff;
      pt_wdata   = pa_ff;
      cyc_wdata  = 1'b0;
      par_wdata  = 1'b1;

      case (state_ff)
         ST_CLEAR: begin
            lk_we     = 1'b1;
            pt_we     = 1'b1;
            cyc_we    = 1'b1;
            par_we    = 1'b1;
            lk_waddr  = clr_ff;
            nd_waddr  = clr_ff;
            lk_wdata  = '0;
            pt_wdata  = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == VERT_W'(DEPTH - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cur_in = q_item;
               res_in = '0;
               case (q_item.kind)
                  KIND_BAD_INSERT: begin
                     res_in.status = STAT_INTERIOR;
                     state_in      = ST_OUT;
                  end
                  KIND_BAD_READ: begin
                     res_in.status = STAT_READ;
                     state_in      = ST_OUT;
                  end
                  default: state_in = ST_RB;
               endcase
            end
         end
         ST_RB: begin
            la_in   = lk_rd_ff;
            pa_in   = pt_rd_ff;
            para_in = par_rd_ff;
            rd_addr = cur_ff.b;
            if (cur_ff.kind == KIND_READ) begin
               res_in.status = STAT_READ;
               res_in.rl     = lk_rd_ff.rl;
               res_in.ll     = lk_rd_ff.ll;
               res_in.rw     = (lk_rd_ff.rl != '0) ? lk_rd_ff.rw : '0;
               res_in.lw     = (lk_rd_ff.ll != '0) ? lk_rd_ff.lw : '0;
               res_in.far    = pt_rd_ff;
               res_in.cyc    = cyc_rd_ff;
               res_in.par    = par_rd_ff;
               state_in      = ST_OUT;
            end else begin
               state_in = ST_EV;
            end
         end
         ST_EV: begin
            state_in   = ST_OUT;
            w2_link_in = attach(lk_rd_ff, cur_ff.a, cur_ff.wt);
            w2_addr_in = cur_ff.b;
            w2_ptwe_in = 1'b0;
            w2_pt_in   = pa_ff;
            w2_par_in  = 1'b1;
            if (interior(la_ff) || interior(lk_rd_ff)) begin
               res_in.status = STAT_INTERIOR;
            end else if (cur_ff.a == cur_ff.b) begin
               res_in.status = STAT_ODD;
            end else if (pa_ff == cur_ff.b) begin
               if (para_ff) begin
                  res_in.status = STAT_ODD;
               end else begin
                  res_in.status = STAT_CLOSED;
                  sum_in    = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
                  lk_we     = 1'b1;
                  lk_wdata  = attach(la_ff, cur_ff.b, cur_ff.wt);
                  par_we    = 1'b1;
                  cyc_we    = 1'b1;
                  cyc_wdata = 1'b1;
                  state_in  = ST_W2;
               end
            end else begin
               res_in.status = STAT_MERGED;
               sum_in     = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
               lk_we      = 1'b1;
               lk_wdata   = attach(la_ff, cur_ff.b, cur_ff.wt);
               pt_we      = 1'b1;
               par_we     = 1'b1;
               nd_waddr   = pa_ff;
               pt_wdata   = pt_rd_ff;
               par_wdata  = para_ff ^ par_rd_ff;
               w2_addr_in = pt_rd_ff;
               w2_ptwe_in = 1'b1;
               w2_pt_in   = pa_ff;
               w2_par_in  = para_ff ^ par_rd_ff;
               state_in   = ST_W2;
            end
         end
         ST_W2: begin
            lk_we     = 1'b1;
            lk_waddr  = cur_ff.b;
            lk_wdata  = w2_link_ff;
            pt_we     = w2_ptwe_ff;
            par_we    = 1'b1;
            nd_waddr  = w2_addr_ff;
            pt_wdata  = w2_pt_ff;
            par_wdata = w2_par_ff;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rv_in    = 1'b1;
               ro_in    = res_ff;
               rt_in    = sum_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (lk_we)
         link_mem[lk_waddr] <= lk_wdata;
      if (pt_we)
         partner_mem[nd_waddr] <= pt_wdata;
      if (cyc_we)
         cyc_mem[nd_waddr] <= cyc_wdata;
      if (par_we)
         par_mem[nd_waddr] <= par_wdata;
      lk_rd_ff  <= link_mem[rd_addr];
      pt_rd_ff  <= partner_mem[rd_addr];
      cyc_rd_ff <= cyc_mem[rd_addr];
      par_rd_ff <= par_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         sum_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         sum_ff   <= sum_in;
         rv_ff    <= rv_in;
      end
      cur_ff     <= cur_in;
      la_ff      <= la_in;
      pa_ff      <= pa_in;
      para_ff    <= para_in;
      res_ff     <= res_in;
      w2_link_ff <= w2_link_in;
      w2_addr_ff <= w2_addr_in;
      w2_pt_ff   <= w2_pt_in;
      w2_ptwe_ff <= w2_ptwe_in;
      w2_par_ff  <= w2_par_in;
      ro_ff      <= ro_in;
      rt_ff      <= rt_in;
   end

   assign stat.clearing = (state_ff == ST_CLEAR);
   assign stat.pop      = pop;

   assign rsp_valid             = rv_ff;
   assign rsp_status            = ro_ff.status;
   assign rsp_right_neighbor    = ro_ff.rl;
   assign rsp_left_neighbor     = ro_ff.ll;
   assign rsp_right_link_weight = ro_ff.rw;
   assign rsp_left_link_weight  = ro_ff.lw;
   assign rsp_far_endpoint      = ro_ff.far;
   assign rsp_in_cycle          = ro_ff.cyc;
   assign rsp_odd_count         = ro_ff.par;
   assign rsp_total_weight      = rt_ff;

   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !pop)
      else $error("request taken during table clear");

   a_w2_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_W2 |-> $past(state_ff) == ST_EV)
      else $error("second write without evaluation");

   a_sum_mono: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_CLEAR |=> sum_ff >= $past(sum_ff))
      else $error("weight sum decreased");

   a_insert_zero: assert property (@(posedge clock) disable iff (reset)
      rv_ff && ro_ff.status != STAT_READ |-> ro_ff.rl == '0 && ro_ff.far == '0)
      else $error("insert result carries entry data");

endmodule

@@ verif/pcef_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcef_checker
// Tracks the vertex link table from the accepted requests, predicts each
// response and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module pcef_checker import pcef_pkg::*; #(
   parameter int MAX_VERTICES = 1023
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic                req_type,
   input  logic [VERT_W-1:0]   req_vertex_a,
   input  logic [VERT_W-1:0]   req_vertex_b,
   input  logic [WT_W-1:0]     req_edge_weight,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic [2:0]          rsp_status,
   input  logic [VERT_W-1:0]   rsp_right_neighbor,
   input  logic [VERT_W-1:0]   rsp_left_neighbor,
   input  logic [WT_W-1:0]     rsp_right_link_weight,
   input  logic [WT_W-1:0]     rsp_left_link_weight,
   input  logic [VERT_W-1:0]   rsp_far_endpoint,
   input  logic                rsp_in_cycle,
   input  logic                rsp_odd_count,
   input  logic [SUM_W-1:0]    rsp_total_weight,
   output int                  errors,
   output int                  pending,
   output int                  closed_cnt,
   output int                  merged_cnt
);

   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef struct packed {
      status_type          status;
      logic [VERT_W-1:0]   rl;
      logic [VERT_W-1:0]   ll;
      logic [WT_W-1:0]     rw;
      logic [WT_W-1:0]     lw;
      logic [VERT_W-1:0]   far;
      logic                cyc;
      logic                par;
      logic [SUM_W-1:0]    total;
   } entry_view_type;

   logic [VERT_W-1:0] rlink [DEPTH];
   logic [VERT_W-1:0] llink [DEPTH];
   logic [WT_W-1:0]   rwt   [DEPTH];
   logic [WT_W-1:0]   lwt   [DEPTH];
   logic [VERT_W-1:0] partner [DEPTH];
   logic              cmark [DEPTH];
   logic              odd   [DEPTH];
   logic [SUM_W-1:0]  wsum;
   entry_view_type    expected_rsp_q [$];

   function automatic logic vertex_ok(logic [VERT_W-1:0] v);
      return v >= 1 && v <= MAX_VERTICES;
   endfunction

   function automatic logic is_interior(logic [VERT_W-1:0] v);
      return rlink[v] != '0 && llink[v] != '0;
   endfunction

   function automatic void link_to(logic [VERT_W-1:0] v, logic [VERT_W-1:0] to,
                                   logic [WT_W-1:0] w);
      if (rlink[v] == '0) begin
         rlink[v] = to;
         rwt[v]   = w;
      end else begin
         llink[v] = to;
         lwt[v]   = w;
      end
   endfunction

   function automatic void accumulate(logic [WT_W-1:0] w);
      logic [SUM_W:0] s;
      s = {1'b0, wsum} + (SUM_W+1)'(w);
      wsum = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
   endfunction

   function automatic status_type insert_edge(logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                                             logic [WT_W-1:0] w);
      logic [VERT_W-1:0] oa, ob;
      logic np;
      if (!vertex_ok(a) || !vertex_ok(b)) return STAT_INTERIOR;
      if (is_interior(a) || is_interior(b)) return STAT_INTERIOR;
      if (a == b) return STAT_ODD;
      if (partner[a] == b) begin
         if (odd[a]) return STAT_ODD;
         accumulate(w);
         odd[a] = 1'b1;
         odd[b] = 1'b1;
         link_to(a, b, w);
         link_to(b, a, w);
         cmark[a] = 1'b1;
         return STAT_CLOSED;
      end
      accumulate(w);
      oa = partner[a];
      ob = partner[b];
      np = odd[a] ^ odd[b];
      odd[oa] = np;
      odd[ob] = np;
      partner[oa] = ob;
      partner[ob] = oa;
      link_to(a, b, w);
      link_to(b, a, w);
      return STAT_MERGED;
   endfunction

   function automatic entry_view_type predict_response(logic t, logic [VERT_W-1:0] a,
                                                       logic [VERT_W-1:0] b,
                                                       logic [WT_W-1:0] w);
      entry_view_type e;
      e = '0;
      if (!t) begin
         e.status = insert_edge(a, b, w);
      end else begin
         e.status = STAT_READ;
         if (vertex_ok(a)) begin
            e.rl  = rlink[a];
            e.ll  = llink[a];
            e.rw  = (rlink[a] != '0) ? rwt[a] : '0;
            e.lw  = (llink[a] != '0) ? lwt[a] : '0;
            e.far = partner[a];
            e.cyc = cmark[a];
            e.par = odd[a];
         end
      end
      e.total = wsum;
      return e;
   endfunction

   task automatic cmp(string name, logic [SUM_W-1:0] exp_v, logic [SUM_W-1:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      entry_view_type e;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            rlink[i] = '0;
            llink[i] = '0;
            rwt[i] = '0;
            lwt[i] = '0;
            partner[i] = i[VERT_W-1:0];
            cmark[i] = 1'b0;
            odd[i] = 1'b1;
         end
         wsum = '0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               errors++;
               $error("response with no request outstanding");
            end else begin
               e = expected_rsp_q.pop_front();
               cmp("status", SUM_W'(e.status), SUM_W'(rsp_status));
               cmp("right_neighbor", SUM_W'(e.rl), SUM_W'(rsp_right_neighbor));
               cmp("left_neighbor", SUM_W'(e.ll), SUM_W'(rsp_left_neighbor));
               cmp("right_link_weight", SUM_W'(e.rw), SUM_W'(rsp_right_link_weight));
               cmp("left_link_weight", SUM_W'(e.lw), SUM_W'(rsp_left_link_weight));
               cmp("far_endpoint", SUM_W'(e.far), SUM_W'(rsp_far_endpoint));
               cmp("in_cycle", SUM_W'(e.cyc), SUM_W'(rsp_in_cycle));
               cmp("odd_count", SUM_W'(e.par), SUM_W'(rsp_odd_count));
               cmp("total_weight", e.total, rsp_total_weight);
               if (e.status == STAT_CLOSED) closed_cnt++;
               if (e.status == STAT_MERGED) merged_cnt++;
            end
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(predict_response(req_type, req_vertex_a,
                                                      req_vertex_b, req_edge_weight));
      end
      pending = expected_rsp_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
      closed_cnt = 0;
      merged_cnt = 0;
   end

endmodule

@@ verif/path_cycle_edge_filter_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_cycle_edge_filter_unit_tb
// Drives directed and windowed random edge inserts and table reads through
// the filter under several idle/stall mixes and a long output hold-off.
// ----------------------------------------------------------------------------
module path_cycle_edge_filter_unit_tb import pcef_pkg::*; ();

   localparam int WDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES = 300;
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_READ   = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_type = 1'b0;
   logic [VERT_W-1:0] req_vertex_a = '0;
   logic [VERT_W-1:0] req_vertex_b = '0;
   logic [WT_W-1:0] req_edge_weight = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [2:0] rsp_status;
   logic [VERT_W-1:0] rsp_right_neighbor, rsp_left_neighbor, rsp_far_endpoint;
   logic [WT_W-1:0] rsp_right_link_weight, rsp_left_link_weight;
   logic rsp_in_cycle, rsp_odd_count;
   logic [SUM_W-1:0] rsp_total_weight;

   int errors, pending, closed_cnt, merged_cnt;
   int idle_pct = 0;
   int stall_pct = 0;
   bit hold_req = 0;
   int sent = 0;
   int quiet = 0;

   always #4 clock = ~clock;

   path_cycle_edge_filter_unit u_dut (.*);

   pcef_checker u_chk (.*);

   always @(posedge clock) begin
      if (hold_req) begin
         rsp_stall <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         hold_req = 0;
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= WDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic send(logic t, logic [VERT_W-1:0] a, logic [VERT_W-1:0] b,
                       logic [WT_W-1:0] w);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_vertex_a <= VERT_W'($urandom);
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t;
      req_vertex_a <= a;
      req_vertex_b <= b;
      req_edge_weight <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic random_phase(int n, int ip, int sp);
      int r, base;
      logic [VERT_W-1:0] a, b;
      logic [WT_W-1:0] w;
      idle_pct = ip;
      stall_pct = sp;
      for (int i = 0; i < n; i++) begin
         base = 1 + ((sent / 50) * 9) % 1010;
         r = $urandom_range(99);
         a = VERT_W'(base + $urandom_range(9));
         b = VERT_W'(base + $urandom_range(9));
         w = $urandom;
         if ($urandom_range(9) == 0) w = $urandom_range(1) ? '1 : '0;
         if (r < 22) send(REQ_READ, a, VERT_W'($urandom), WT_W'($urandom));
         else if (r < 26) send(REQ_READ, VERT_W'($urandom), VERT_W'($urandom),
                               WT_W'($urandom));
         else if (r < 29) send(REQ_INSERT, $urandom_range(1) ? '0 : a, '0, w);
         else if (r < 36) send(REQ_INSERT, VERT_W'($urandom_range(1, 1023)),
                               VERT_W'($urandom_range(1, 1023)), w);
         else send(REQ_INSERT, a, b, w);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // directed: bad vertices, self-loop, even cycle close, odd reject, interior
      send(REQ_READ, 0, 0, 0);
      send(REQ_READ, 1023, 0, 0);
      send(REQ_INSERT, 0, 5, 7);
      send(REQ_INSERT, 5, 0, 7);
      send(REQ_INSERT, 5, 5, 7);
      send(REQ_INSERT, 1023, 1022, '1);
      send(REQ_INSERT, 1, 2, 10);
      send(REQ_INSERT, 2, 3, 20);
      send(REQ_INSERT, 3, 4, 0);
      send(REQ_READ, 1, 0, 0);
      send(REQ_INSERT, 4, 1, 40);
      send(REQ_READ, 4, 0, 0);
      send(REQ_READ, 1, 0, 0);
      send(REQ_INSERT, 2, 9, 50);
      send(REQ_INSERT, 10, 11, 1);
      send(REQ_INSERT, 11, 12, 2);
      send(REQ_INSERT, 12, 10, 3);
      send(REQ_READ, 10, 0, 0);
      send(REQ_READ, 11, 0, 0);
      send(REQ_READ, 1022, 0, 0);
      send(REQ_READ, 682, 0, 0);
      random_phase(300, 0, 0);
      random_phase(250, 79, 0);
      random_phase(250, 0, 79);
      hold_req = 1;
      random_phase(150, 0, 0);
      random_phase(350, 28, 28);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d requests; %0d merges and %0d cycle closures checked,",
               sent, merged_cnt, closed_cnt);
      $display("under idle, stall, mixed and long output hold-off phases.");
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

@@ sim.f @@
design/pcef_pkg.sv
design/pcef_front.sv
design/pcef_queue.sv
design/pcef_back.sv
design/path_cycle_edge_filter_unit.sv
verif/pcef_checker.sv
verif/path_cycle_edge_filter_unit_tb.sv
